[rtl/rsi_pkg.sv]
`default_nettype none

package rsi_pkg;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int SECONDS_BITS_DEF = 24;

   localparam int CHANNEL_W  = 3;
   localparam int MINUTE_W   = 11;
   localparam int WINDOW_W   = 2 * MINUTE_W;
   localparam int MAXON_W    = 24;
   localparam int MAXON_REGS = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int UPC_W      = 3;

   typedef enum logic [1:0] {
      CMD_QUERY  = 2'd0,
      CMD_REPORT = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_POLICY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ANSWER     = 2'd0,
      KIND_FORCED_OFF = 2'd1,
      KIND_DONE       = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REASON_AWAY     = 2'd0,
      REASON_SCHEDULE = 2'd1,
      REASON_MAX_ON   = 2'd2
   } reason_type;

   typedef enum logic [2:0] {
      REG_AWAY_MODE        = 3'd0,
      REG_SCHEDULE_ENFORCE = 3'd1,
      REG_WINDOW_ONE       = 3'd2,
      REG_WINDOW_TWO       = 3'd3,
      REG_MAX_ON_CH1       = 3'd4,
      REG_MAX_ON_CH2       = 3'd5,
      REG_MAX_ON_CH3       = 3'd6,
      REG_MAX_ON_CH4       = 3'd7
   } reg_idx_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_QUERY     = 3'd1,
      ACT_REPORT    = 3'd2,
      ACT_TICK      = 3'd3,
      ACT_SCHED_OFF = 3'd4,
      ACT_LIMIT_OFF = 3'd5,
      ACT_DONE      = 3'd6
   } act_type;

   typedef enum logic [1:0] {
      JMP_DISPATCH = 2'd0,
      JMP_GOTO     = 2'd1,
      JMP_LOOP     = 2'd2
   } jmp_type;

   localparam logic [UPC_W-1:0] UPC_IDLE      = 3'd0;
   localparam logic [UPC_W-1:0] UPC_QUERY     = 3'd1;
   localparam logic [UPC_W-1:0] UPC_REPORT    = 3'd2;
   localparam logic [UPC_W-1:0] UPC_TICK      = 3'd3;
   localparam logic [UPC_W-1:0] UPC_SCHED_OFF = 3'd4;
   localparam logic [UPC_W-1:0] UPC_LIMIT_OFF = 3'd5;
   localparam logic [UPC_W-1:0] UPC_DONE      = 3'd6;

   typedef struct packed {
      act_type             act;
      jmp_type             jmp;
      logic [UPC_W-1:0]    target;
   } uop_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [CHANNEL_W-1:0]   channel;
      logic                   turned_on;
      logic [MINUTE_W-1:0]    minute_now;
   } req_word_type;

   typedef struct packed {
      kind_type               kind;
      logic [CHANNEL_W-1:0]   out_channel;
      logic                   allowed;
      reason_type             off_reason;
      logic                   last;
   } rsp_word_type;

   typedef struct packed {
      logic                                  away_mode;
      logic                                  schedule_enforce;
      logic [WINDOW_W-1:0]                   window_one;
      logic [WINDOW_W-1:0]                   window_two;
      logic [MAXON_REGS-1:0][MAXON_W-1:0]    max_on;
   } cfg_type;

   typedef struct packed {
      logic    accept;
      act_type act;
   } seq_ctrl_type;

   typedef struct packed {
      logic hold;
   } dp_status_type;

   function automatic uop_type ucode_rom(input logic [UPC_W-1:0] addr);
      uop_type u;
      unique case (addr)
         UPC_IDLE:      u = '{act: ACT_NONE,      jmp: JMP_DISPATCH, target: UPC_IDLE};
         UPC_QUERY:     u = '{act: ACT_QUERY,     jmp: JMP_GOTO,     target: UPC_IDLE};
         UPC_REPORT:    u = '{act: ACT_REPORT,    jmp: JMP_GOTO,     target: UPC_IDLE};
         UPC_TICK:      u = '{act: ACT_TICK,      jmp: JMP_LOOP,     target: UPC_IDLE};
         UPC_SCHED_OFF: u = '{act: ACT_SCHED_OFF, jmp: JMP_LOOP,     target: UPC_LIMIT_OFF};
         UPC_LIMIT_OFF: u = '{act: ACT_LIMIT_OFF, jmp: JMP_LOOP,     target: UPC_DONE};
         UPC_DONE:      u = '{act: ACT_DONE,      jmp: JMP_GOTO,     target: UPC_IDLE};
         default:       u = '{act: ACT_NONE,      jmp: JMP_GOTO,     target: UPC_IDLE};
      endcase
      return u;
   endfunction

   function automatic logic [UPC_W-1:0] dispatch_target(input cmd_type cmd);
      logic [UPC_W-1:0] t;
      unique case (cmd)
         CMD_QUERY:  t = UPC_QUERY;
         CMD_REPORT: t = UPC_REPORT;
         CMD_TICK:   t = UPC_TICK;
         CMD_POLICY: t = UPC_SCHED_OFF;
         default:    t = UPC_IDLE;
      endcase
      return t;
   endfunction

   function automatic logic in_window(input logic [WINDOW_W-1:0] win,
                                      input logic [MINUTE_W-1:0] minute);
      logic [MINUTE_W-1:0] s;
      logic [MINUTE_W-1:0] e;
      logic                hit;
      s = win[WINDOW_W-1:MINUTE_W];
      e = win[MINUTE_W-1:0];
      if (s == e) begin
         hit = 1'b0;
      end else if (s < e) begin
         hit = (minute >= s) && (minute < e);
      end else begin
         hit = (minute >= s) || (minute < e);
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

[rtl/rsi_csr.sv]
`default_nettype none

module rsi_csr import rsi_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output cfg_type                     cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx) inside
            REG_AWAY_MODE:        cfg_in.away_mode        = csr_pwdata[0];
            REG_SCHEDULE_ENFORCE: cfg_in.schedule_enforce = csr_pwdata[0];
            REG_WINDOW_ONE:       cfg_in.window_one       = csr_pwdata[WINDOW_W-1:0];
            REG_WINDOW_TWO:       cfg_in.window_two       = csr_pwdata[WINDOW_W-1:0];
            REG_MAX_ON_CH1, REG_MAX_ON_CH2, REG_MAX_ON_CH3, REG_MAX_ON_CH4: begin
               cfg_in.max_on[idx[1:0]] = csr_pwdata[MAXON_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_AWAY_MODE:        csr_prdata = CSR_DATA_W'(cfg_ff.away_mode);
         REG_SCHEDULE_ENFORCE: csr_prdata = CSR_DATA_W'(cfg_ff.schedule_enforce);
         REG_WINDOW_ONE:       csr_prdata = CSR_DATA_W'(cfg_ff.window_one);
         REG_WINDOW_TWO:       csr_prdata = CSR_DATA_W'(cfg_ff.window_two);
         REG_MAX_ON_CH1:       csr_prdata = CSR_DATA_W'(cfg_ff.max_on[0]);
         REG_MAX_ON_CH2:       csr_prdata = CSR_DATA_W'(cfg_ff.max_on[1]);
         REG_MAX_ON_CH3:       csr_prdata = CSR_DATA_W'(cfg_ff.max_on[2]);
         REG_MAX_ON_CH4:       csr_prdata = CSR_DATA_W'(cfg_ff.max_on[3]);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rsi_useq.sv]
`default_nettype none

module rsi_useq import rsi_pkg::*; #(
   parameter  int NUM_CHANNELS = NUM_CHANNELS_DEF,
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire cmd_type         req_cmd,
   output logic                 req_stall,
   input  wire dp_status_type   status,
   output seq_ctrl_type         ctrl,
   output logic [CH_W-1:0]      cnt
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic [CH_W-1:0]  cnt_ff;
   logic [CH_W-1:0]  cnt_in;
   uop_type          uop;
   logic             cnt_last;
   logic             accept;

   assign uop       = ucode_rom(upc_ff);
   assign cnt_last  = (cnt_ff == CH_W'(NUM_CHANNELS - 1));
   assign req_stall = reset || (upc_ff != UPC_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ctrl      = '{accept: accept, act: uop.act};
   assign cnt       = cnt_ff;

   always_comb begin
      upc_in = upc_ff;
      cnt_in = cnt_ff;
      if (!status.hold) begin
         unique case (uop.jmp)
            JMP_DISPATCH: begin
               if (accept) begin
                  upc_in = dispatch_target(req_cmd);
               end
            end
            JMP_GOTO: upc_in = uop.target;
            JMP_LOOP: begin
               if (cnt_last) begin
                  upc_in = uop.target;
                  cnt_in = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            default: upc_in = UPC_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
         cnt_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rsi_dpath.sv]
`default_nettype none

module rsi_dpath import rsi_pkg::*; #(
   parameter  int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter  int SECONDS_BITS = SECONDS_BITS_DEF,
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire seq_ctrl_type    ctrl,
   input  wire logic [CH_W-1:0] cnt,
   input  wire cfg_type         cfg,
   input  wire req_word_type    req_word,
   input  wire logic            rsp_stall,
   output logic                 rsp_valid,
   output rsp_word_type         rsp_word,
   output dp_status_type        status
);

   localparam int CMP_W = (SECONDS_BITS > MAXON_W) ? SECONDS_BITS : MAXON_W;

   logic [NUM_CHANNELS-1:0] relay_on_ff;
   logic [NUM_CHANNELS-1:0] relay_on_in;
   logic [NUM_CHANNELS-1:0] tracked_ff;
   logic [NUM_CHANNELS-1:0] tracked_in;
   logic [SECONDS_BITS-1:0] sec_ff [NUM_CHANNELS];
   logic [SECONDS_BITS-1:0] sec_in [NUM_CHANNELS];

   req_word_type            req_ff;
   rsp_word_type            rsp_word_ff;
   rsp_word_type            rsp_word_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic                    in_sched;
   logic                    ch_ok;
   logic                    sel_on;
   logic                    sel_tracked;
   logic [SECONDS_BITS-1:0] sel_sec;
   logic [MAXON_W-1:0]      lim;
   logic                    sched_off;
   logic                    limit_off;
   logic                    emit;
   logic                    busy;
   logic                    fire;

   assign in_sched    = in_window(cfg.window_one, req_ff.minute_now)
                     || in_window(cfg.window_two, req_ff.minute_now);
   assign ch_ok       = (req_ff.channel != '0) && (int'(req_ff.channel) <= NUM_CHANNELS);
   assign sel_on      = relay_on_ff[cnt];
   assign sel_tracked = tracked_ff[cnt];
   assign sel_sec     = sec_ff[cnt];

   always_comb begin
      lim = '0;
      for (int j = 0; j < MAXON_REGS; j++) begin
         if (j < NUM_CHANNELS && int'(cnt) == j) begin
            lim = cfg.max_on[j];
         end
      end
   end

   assign sched_off = (cfg.away_mode || (cfg.schedule_enforce && !in_sched)) && sel_on;
   assign limit_off = sel_on && sel_tracked && (lim != '0)
                   && (CMP_W'(sel_sec) >= CMP_W'(lim));

   always_comb begin
      emit        = 1'b0;
      rsp_word_in = '{kind: KIND_ANSWER, out_channel: '0, allowed: 1'b0,
                      off_reason: REASON_AWAY, last: 1'b0};
      unique case (ctrl.act)
         ACT_QUERY: begin
            emit                    = 1'b1;
            rsp_word_in.out_channel = req_ff.channel;
            rsp_word_in.allowed     = ch_ok && !cfg.away_mode
                                   && (!cfg.schedule_enforce || in_sched);
            rsp_word_in.last        = 1'b1;
         end
         ACT_SCHED_OFF: begin
            emit                    = sched_off;
            rsp_word_in.kind        = KIND_FORCED_OFF;
            rsp_word_in.out_channel = CHANNEL_W'(int'(cnt) + 1);
            rsp_word_in.off_reason  = cfg.away_mode ? REASON_AWAY : REASON_SCHEDULE;
         end
         ACT_LIMIT_OFF: begin
            emit                    = limit_off;
            rsp_word_in.kind        = KIND_FORCED_OFF;
            rsp_word_in.out_channel = CHANNEL_W'(int'(cnt) + 1);
            rsp_word_in.off_reason  = REASON_MAX_ON;
         end
         ACT_DONE: begin
            emit             = 1'b1;
            rsp_word_in.kind = KIND_DONE;
            rsp_word_in.last = 1'b1;
         end
         default: ;
      endcase
   end

   assign busy        = rsp_valid_ff && rsp_stall;
   assign fire        = emit && !busy;
   assign status.hold = emit && busy;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      relay_on_in = relay_on_ff;
      tracked_in  = tracked_ff;
      for (int j = 0; j < NUM_CHANNELS; j++) begin
         sec_in[j] = sec_ff[j];
         if (ctrl.act == ACT_REPORT && ch_ok && int'(req_ff.channel) == j + 1) begin
            relay_on_in[j] = req_ff.turned_on;
            tracked_in[j]  = req_ff.turned_on;
            sec_in[j]      = '0;
         end
         if (ctrl.act == ACT_TICK && int'(cnt) == j && tracked_ff[j]
             && sec_ff[j] != '1) begin
            sec_in[j] = sec_ff[j] + 1'b1;
         end
         if ((ctrl.act == ACT_SCHED_OFF || ctrl.act == ACT_LIMIT_OFF) && fire
             && int'(cnt) == j) begin
            relay_on_in[j] = 1'b0;
            tracked_in[j]  = 1'b0;
            sec_in[j]      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_on_ff  <= '0;
         tracked_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NUM_CHANNELS; j++) begin
            sec_ff[j] <= '0;
         end
      end else begin
         relay_on_ff  <= relay_on_in;
         tracked_ff   <= tracked_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int j = 0; j < NUM_CHANNELS; j++) begin
            sec_ff[j] <= sec_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         req_ff <= req_word;
      end
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

[rtl/relay_safety_interlock.sv]
// a query word is captured in the request register, then its answer in the output register
// one command is taken at a time; query and report go straight back to idle; tick walks
// channels one a step; policy walks them for schedule, again for max-on, then sends done
// the microcode steps one control word a cycle while no stalled output word holds it
// reset: synchronous, clears configuration, relay state and the output valid flag
`default_nettype none

module relay_safety_interlock import rsi_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int SECONDS_BITS = SECONDS_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_word_type           req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_word_type                rsp_word,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   cfg_type         cfg;
   seq_ctrl_type    ctrl;
   dp_status_type   status;
   logic [CH_W-1:0] cnt;

   rsi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rsi_useq #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_word.cmd),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl),
      .cnt       (cnt)
   );

   rsi_dpath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SECONDS_BITS (SECONDS_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cnt       (cnt),
      .cfg       (cfg),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .status    (status)
   );

endmodule

`default_nettype wire

[rtl/rsi_checker.sv]
`default_nettype none

module rsi_checker import rsi_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_word_type req_word,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_word
);

   logic query_acc;

   assign query_acc = req_valid && !req_stall && (req_word.cmd == CMD_QUERY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed or dropped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in work");

   a_query_answer: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(query_acc, 2) && !$past(rsp_valid, 2)
      |-> rsp_valid && rsp_word.kind == KIND_ANSWER && rsp_word.last)
      else $error("query answer missing two cycles after accept");

   a_forced_off_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == KIND_FORCED_OFF
      |-> !rsp_word.last && rsp_word.out_channel != '0 && !rsp_word.allowed)
      else $error("malformed forced off word");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == KIND_DONE
      |-> rsp_word.last && rsp_word.out_channel == '0)
      else $error("malformed done word");

endmodule

bind relay_safety_interlock rsi_checker u_rsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire
